// ----- hw/rtl/bc_pkg.sv -----
// ----------------------------------------------------------------------------
// bc_pkg
// Shared types, constants and helpers for the betweenness centrality core.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRC_FIRST,
    OP_SRC_NEXT,
    OP_SEARCH_INIT,
    OP_HEAD_RD,
    OP_ROW_RD,
    OP_V_LATCH,
    OP_W_RD,
    OP_W_UPD,
    OP_W_NEXT,
    OP_ACC_INIT,
    OP_ORD_RD,
    OP_WSEL,
    OP_W_LATCH,
    OP_PRED_RD,
    OP_MUL,
    OP_DIV_START,
    OP_DEP_WR,
    OP_V_NEXT,
    OP_SUM_RD,
    OP_SUM_WR,
    OP_V_FIRST,
    OP_E_RD,
    OP_OUT_LOAD,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic row_vld_s;
    logic head_lt_tail;
    logic rowv_w;
    logic w_last;
    logic v_last;
    logic s_last;
    logic visited_v;
    logic pred_hit;
    logic div_busy;
    logic w_is_src;
    logic i_zero;
    logic seen_v;
    logic out_valid;
  } st_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- hw/rtl/bc_div.sv -----
// ----------------------------------------------------------------------------
// bc_div
// Restoring 64 by 32 bit divider, one quotient bit a cycle, saturating result.
// ----------------------------------------------------------------------------
module bc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem, quo[63]};
  assign ge = sh >= {1'b0, dvs};
  assign quotient = (|quo[63:32]) ? 32'hFFFF_FFFF : quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? 32'(sh - {1'b0, dvs}) : sh[31:0];
      quo  <= {quo[62:0], ge};
      cnt  <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/bc_datapath.sv -----
// ----------------------------------------------------------------------------
// bc_datapath
// Graph store, search scratch memories, counters and the output word register.
// ----------------------------------------------------------------------------
module bc_datapath #(
  parameter int NV = 64,
  parameter int VW = 6,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  bc_pkg::op_t   op,
  output bc_pkg::st_t   st,
  input  logic [5:0]    from_vertex,
  input  logic [5:0]    to_vertex,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    vertex_id,
  output logic [31:0]   centrality,
  output logic          last_result
);

  logic [NV-1:0] adj [NV];
  logic [6:0]    dist_mem [NV];
  logic [31:0]   pc_mem [NV];
  logic [31:0]   dep_mem [NV];
  logic [VW-1:0] ord_mem [NV];
  logic [31:0]   sum_mem [NV];

  logic [NV-1:0] row_vld;
  logic [NV-1:0] seen;
  logic [NV-1:0] sum_vld;
  logic [NV-1:0] visited;

  logic [VW-1:0] s, v, w;
  logic [CW-1:0] head, tail, i;
  logic [CW-1:0] im1;

  logic [NV-1:0] row_q;
  logic          row_vq;
  logic [NV-1:0] row_m;
  logic [6:0]    dist_q;
  logic [31:0]   pc_q, dep_q;
  logic [VW-1:0] order_q;
  logic [31:0]   sum_q;
  logic          sum_vq;
  logic [31:0]   sum_m;

  logic [NV-1:0] rowv;
  logic [6:0]    dv, dw;
  logic [31:0]   pcv, onep, divr, depw;
  logic [63:0]   prod;

  logic          div_busy;
  logic [31:0]   div_quo;

  logic          in_range;
  logic [VW-1:0] fi, ti;
  logic          new_w, match;

  logic          dist_we, pc_we, dep_we, ord_we;
  logic [VW-1:0] sc_wa, dep_wa, ord_wa, sc_ra, ord_ra, adj_ra, sum_ra;
  logic [6:0]    dist_wd;
  logic [31:0]   pc_wd, dep_wd;
  logic [VW-1:0] ord_wd;
  logic          init;

  bc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == bc_pkg::OP_DIV_START),
    .dividend (prod),
    .divisor  (divr),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_range = ({1'b0, from_vertex} < 7'(NV)) && ({1'b0, to_vertex} < 7'(NV));
  assign fi       = from_vertex[VW-1:0];
  assign ti       = to_vertex[VW-1:0];
  assign im1      = i - CW'(1);
  assign row_m    = row_vq ? row_q : '0;
  assign sum_m    = sum_vq ? sum_q : '0;
  assign init     = op == bc_pkg::OP_SEARCH_INIT;
  assign new_w    = !visited[w];
  assign match    = {1'b0, dist_q} == ({1'b0, dv} + 8'd1);

  assign dist_we = init || (op == bc_pkg::OP_W_UPD && new_w);
  assign pc_we   = init || (op == bc_pkg::OP_W_UPD && (new_w || match));
  assign dep_we  = dist_we || op == bc_pkg::OP_DEP_WR;
  assign ord_we  = dist_we;
  assign sc_wa   = init ? s : w;
  assign dep_wa  = (op == bc_pkg::OP_DEP_WR) ? v : sc_wa;
  assign ord_wa  = init ? '0 : tail[VW-1:0];
  assign dist_wd = init ? 7'd0 : dv + 7'd1;
  assign pc_wd   = init ? 32'd1 : (new_w ? pcv : bc_pkg::sat_add32(pc_q, pcv));
  assign dep_wd  = (op == bc_pkg::OP_DEP_WR) ? bc_pkg::sat_add32(dep_q, div_quo) : 32'd0;
  assign ord_wd  = init ? s : w;

  assign sc_ra  = (op == bc_pkg::OP_ROW_RD || op == bc_pkg::OP_WSEL) ? order_q :
                  (op == bc_pkg::OP_W_RD) ? w : v;
  assign ord_ra = (op == bc_pkg::OP_HEAD_RD) ? head[VW-1:0] : im1[VW-1:0];
  assign adj_ra = (op == bc_pkg::OP_ROW_RD) ? order_q : v;
  assign sum_ra = (op == bc_pkg::OP_SUM_RD) ? w : v;

  always_ff @(posedge clk) begin
    if (op == bc_pkg::OP_LOAD && in_range) begin
      if (!row_vld[fi]) begin
        adj[fi] <= NV'(1) << ti;
      end else begin
        adj[fi][ti] <= 1'b1;
      end
    end
    if (op == bc_pkg::OP_ROW_RD || op == bc_pkg::OP_PRED_RD) begin
      row_q  <= adj[adj_ra];
      row_vq <= row_vld[adj_ra];
    end
    if (dist_we) begin
      dist_mem[sc_wa] <= dist_wd;
    end
    if (pc_we) begin
      pc_mem[sc_wa] <= pc_wd;
    end
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (op == bc_pkg::OP_ROW_RD || op == bc_pkg::OP_W_RD || op == bc_pkg::OP_WSEL ||
        op == bc_pkg::OP_PRED_RD) begin
      dist_q <= dist_mem[sc_ra];
      pc_q   <= pc_mem[sc_ra];
      dep_q  <= dep_mem[sc_ra];
    end
    if (op == bc_pkg::OP_HEAD_RD || op == bc_pkg::OP_ORD_RD) begin
      order_q <= ord_mem[ord_ra];
    end
    if (op == bc_pkg::OP_SUM_WR) begin
      sum_mem[w] <= bc_pkg::sat_add32(sum_m, depw);
    end
    if (op == bc_pkg::OP_SUM_RD || op == bc_pkg::OP_E_RD) begin
      sum_q  <= sum_mem[sum_ra];
      sum_vq <= sum_vld[sum_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld   <= '0;
      seen      <= '0;
      sum_vld   <= '0;
      visited   <= '0;
      out_valid <= 1'b0;
      s         <= '0;
      v         <= '0;
      w         <= '0;
      head      <= '0;
      tail      <= '0;
      i         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        bc_pkg::OP_LOAD: begin
          if (in_range) begin
            row_vld[fi] <= 1'b1;
            seen        <= seen | (NV'(1) << fi) | (NV'(1) << ti);
          end
        end
        bc_pkg::OP_SRC_FIRST: s <= '0;
        bc_pkg::OP_SRC_NEXT:  s <= s + VW'(1);
        bc_pkg::OP_SEARCH_INIT: begin
          visited <= NV'(1) << s;
          head    <= '0;
          tail    <= CW'(1);
        end
        bc_pkg::OP_HEAD_RD: head <= head + CW'(1);
        bc_pkg::OP_V_LATCH: begin
          rowv <= row_m;
          dv   <= dist_q;
          pcv  <= pc_q;
          w    <= '0;
        end
        bc_pkg::OP_W_UPD: begin
          if (new_w) begin
            visited[w] <= 1'b1;
            tail       <= tail + CW'(1);
          end
        end
        bc_pkg::OP_W_NEXT:  w <= w + VW'(1);
        bc_pkg::OP_ACC_INIT: i <= tail;
        bc_pkg::OP_ORD_RD:  i <= im1;
        bc_pkg::OP_WSEL:    w <= order_q;
        bc_pkg::OP_W_LATCH: begin
          onep <= bc_pkg::sat_add32(bc_pkg::Q_ONE, dep_q);
          divr <= (pc_q == 32'd0) ? 32'd1 : pc_q;
          dw   <= dist_q;
          depw <= dep_q;
          v    <= '0;
        end
        bc_pkg::OP_MUL:     prod <= 64'(pc_q) * 64'(onep);
        bc_pkg::OP_V_NEXT:  v <= v + VW'(1);
        bc_pkg::OP_SUM_WR:  sum_vld[w] <= 1'b1;
        bc_pkg::OP_V_FIRST: v <= '0;
        bc_pkg::OP_OUT_LOAD: begin
          out_valid   <= 1'b1;
          vertex_id   <= 6'(v);
          centrality  <= {1'b0, sum_m[31:1]};
          last_result <= ((seen >> v) >> 1) == '0;
        end
        bc_pkg::OP_CLEAR: begin
          row_vld <= '0;
          seen    <= '0;
          sum_vld <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st              = '0;
    st.row_vld_s    = row_vld[s];
    st.head_lt_tail = head < tail;
    st.rowv_w       = rowv[w];
    st.w_last       = w == VW'(NV - 1);
    st.v_last       = v == VW'(NV - 1);
    st.s_last       = s == VW'(NV - 1);
    st.visited_v    = visited[v];
    st.pred_hit     = row_m[w] && (({1'b0, dist_q} + 8'd1) == {1'b0, dw});
    st.div_busy     = div_busy;
    st.w_is_src     = w == s;
    st.i_zero       = i == '0;
    st.seen_v       = seen[v];
    st.out_valid    = out_valid;
  end

endmodule

// ----- hw/rtl/bc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bc_ctrl
// Sequencer: edge loading, per-source search, accumulation, emission, clear.
// ----------------------------------------------------------------------------
module bc_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        last_edge,
  output logic        in_ready,
  input  bc_pkg::st_t st,
  output bc_pkg::op_t op
);

  typedef enum logic [4:0] {
    S_IDLE, S_SRC_FIRST, S_SRC_CHK, S_SRC_STEP, S_HEAD_CHK, S_ROW_RD, S_V_LATCH,
    S_W_CHK, S_W_UPD, S_W_STEP, S_ORD_RD, S_WSEL, S_W_LATCH, S_V_CHK, S_PRED_CHK,
    S_DIV_GO, S_DIV_WAIT, S_V_STEP, S_SUM_CHK, S_SUM_WR, S_ACC_NEXT, S_E_CHK,
    S_E_LOAD, S_E_WAIT, S_E_STEP, S_CLEAR
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    op         = bc_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = bc_pkg::OP_LOAD;
          if (last_edge) state_next = S_SRC_FIRST;
        end
      end
      S_SRC_FIRST: begin
        op = bc_pkg::OP_SRC_FIRST;
        state_next = S_SRC_CHK;
      end
      S_SRC_CHK: begin
        if (st.row_vld_s) begin
          op = bc_pkg::OP_SEARCH_INIT;
          state_next = S_HEAD_CHK;
        end else begin
          state_next = S_SRC_STEP;
        end
      end
      S_SRC_STEP: begin
        if (st.s_last) begin
          op = bc_pkg::OP_V_FIRST;
          state_next = S_E_CHK;
        end else begin
          op = bc_pkg::OP_SRC_NEXT;
          state_next = S_SRC_CHK;
        end
      end
      S_HEAD_CHK: begin
        if (st.head_lt_tail) begin
          op = bc_pkg::OP_HEAD_RD;
          state_next = S_ROW_RD;
        end else begin
          op = bc_pkg::OP_ACC_INIT;
          state_next = S_ORD_RD;
        end
      end
      S_ROW_RD: begin
        op = bc_pkg::OP_ROW_RD;
        state_next = S_V_LATCH;
      end
      S_V_LATCH: begin
        op = bc_pkg::OP_V_LATCH;
        state_next = S_W_CHK;
      end
      S_W_CHK: begin
        if (st.rowv_w) begin
          op = bc_pkg::OP_W_RD;
          state_next = S_W_UPD;
        end else begin
          state_next = S_W_STEP;
        end
      end
      S_W_UPD: begin
        op = bc_pkg::OP_W_UPD;
        state_next = S_W_STEP;
      end
      S_W_STEP: begin
        if (st.w_last) begin
          state_next = S_HEAD_CHK;
        end else begin
          op = bc_pkg::OP_W_NEXT;
          state_next = S_W_CHK;
        end
      end
      S_ORD_RD: begin
        op = bc_pkg::OP_ORD_RD;
        state_next = S_WSEL;
      end
      S_WSEL: begin
        op = bc_pkg::OP_WSEL;
        state_next = S_W_LATCH;
      end
      S_W_LATCH: begin
        op = bc_pkg::OP_W_LATCH;
        state_next = S_V_CHK;
      end
      S_V_CHK: begin
        if (st.visited_v) begin
          op = bc_pkg::OP_PRED_RD;
          state_next = S_PRED_CHK;
        end else begin
          state_next = S_V_STEP;
        end
      end
      S_PRED_CHK: begin
        op = bc_pkg::OP_MUL;
        state_next = st.pred_hit ? S_DIV_GO : S_V_STEP;
      end
      S_DIV_GO: begin
        op = bc_pkg::OP_DIV_START;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!st.div_busy) begin
          op = bc_pkg::OP_DEP_WR;
          state_next = S_V_STEP;
        end
      end
      S_V_STEP: begin
        if (st.v_last) begin
          state_next = S_SUM_CHK;
        end else begin
          op = bc_pkg::OP_V_NEXT;
          state_next = S_V_CHK;
        end
      end
      S_SUM_CHK: begin
        if (st.w_is_src) begin
          state_next = S_ACC_NEXT;
        end else begin
          op = bc_pkg::OP_SUM_RD;
          state_next = S_SUM_WR;
        end
      end
      S_SUM_WR: begin
        op = bc_pkg::OP_SUM_WR;
        state_next = S_ACC_NEXT;
      end
      S_ACC_NEXT: begin
        state_next = st.i_zero ? S_SRC_STEP : S_ORD_RD;
      end
      S_E_CHK: begin
        if (st.seen_v) begin
          op = bc_pkg::OP_E_RD;
          state_next = S_E_LOAD;
        end else begin
          state_next = S_E_STEP;
        end
      end
      S_E_LOAD: begin
        op = bc_pkg::OP_OUT_LOAD;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (!st.out_valid) state_next = S_E_STEP;
      end
      S_E_STEP: begin
        if (st.v_last) begin
          state_next = S_CLEAR;
        end else begin
          op = bc_pkg::OP_V_NEXT;
          state_next = S_E_CHK;
        end
      end
      S_CLEAR: begin
        op = bc_pkg::OP_CLEAR;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/betweenness_centrality_core.sv -----
// ----------------------------------------------------------------------------
// betweenness_centrality_core
// Unweighted betweenness centrality over a loaded adjacency graph.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one directed edge word per handshake,
// from_vertex -> to_vertex; ids at or above MAX_VERTICES (capped at 64) are
// dropped. Loading accepts one word per cycle. A word with last_edge set is
// loaded and then starts the run; in_ready stays low until the run is over.
// The run searches from every vertex with outgoing edges. Each search takes
// the visited vertices in breadth-first order and scans every id in each
// one's row, then walks the visited vertices in reverse order, sweeping all
// ids for predecessors with a multiply and a divide for each one found; the
// bit-serial divider sets most of the run time.
// Output channel (out_valid/out_ready): one word per vertex seen, in
// ascending id, centrality halved in unsigned Q16.16, last_result on the
// final word. A stalled receiver holds the word and pauses the sweep.
// After the last word the graph and sums are cleared and loading resumes.
// Reset (rst, synchronous) empties the graph and returns to loading.
// ----------------------------------------------------------------------------
module betweenness_centrality_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  from_vertex,
  input  logic [5:0]  to_vertex,
  input  logic        last_edge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  vertex_id,
  output logic [31:0] centrality,
  output logic        last_result
);

  localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int VW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);

  bc_pkg::op_t op;
  bc_pkg::st_t st;

  bc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .in_ready  (in_ready),
    .st        (st),
    .op        (op)
  );

  bc_datapath #(
    .NV (NV),
    .VW (VW),
    .CW (CW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .st          (st),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex_id   (vertex_id),
    .centrality  (centrality),
    .last_result (last_result)
  );

endmodule
